// ===== hw/rtl/lcam_pkg.sv =====
// lcam_pkg: shared widths, register indexes and beat types for the
// linear concatenation address map. Depends on nothing.
package lcam_pkg;

  localparam int unsigned SectorW     = 48;
  localparam int unsigned PendW       = 21;
  localparam int unsigned OfferW      = 17;
  localparam int unsigned SizeW       = 40;
  localparam int unsigned CountW      = 3;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned DiskIdxW    = 2;
  localparam int unsigned SectorShift = 9;
  // sector to 1 KiB block
  localparam int unsigned BlockShift  = 1;
  localparam int unsigned BlockW      = SectorW - BlockShift;
  // running offset: at most four nonzero 40-bit sizes
  localparam int unsigned BaseW       = SizeW + 2;
  // sectors left on the hit disk, at most twice a size
  localparam int unsigned RoomW       = SizeW + 2;
  localparam int unsigned WantW       = PendW + 1 - SectorShift;

  localparam int unsigned NumSizeRegs = 4;
  localparam int unsigned MaxDisksDef = 4;

  localparam logic [CountW-1:0]  DiskCountRst = CountW'(1);
  localparam logic [RegIdxW-1:0] RegDiskCount = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegSizeDisk0 = RegIdxW'(1);

  typedef struct packed {
    logic [SectorW-1:0] sector;
    logic [PendW-1:0]   pending_bytes;
    logic [OfferW-1:0]  offered_bytes;
  } lcam_in_t;

  typedef struct packed {
    logic [DiskIdxW-1:0] disk_index;
    logic [SectorW-1:0]  disk_sector;
    logic                out_of_range;
    logic [OfferW-1:0]   merge_bytes;
  } lcam_out_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_index;
    logic [SizeW-1:0]   wdata;
  } lcam_cfg_t;

  // what travels from cell to cell
  typedef struct packed {
    logic [SectorW-1:0]  sector;
    logic [PendW-1:0]    pending_bytes;
    logic [OfferW-1:0]   offered_bytes;
    logic [BaseW-1:0]    base;
    logic                found;
    logic [DiskIdxW-1:0] hit;
    logic [BaseW-1:0]    hit_base;
    logic [BaseW-1:0]    hit_end;
  } lcam_chain_t;

endpackage

// ===== hw/rtl/lcam_stream_if.sv =====
// lcam_stream_if: valid/ready channel carrying one payload beat.
// Payload types come from lcam_pkg.
interface lcam_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lcam_cell.sv =====
// lcam_cell: one disk of the concatenation chain, one register stage.
// Checks the block against this disk's range and passes the offset on.
// Depends on lcam_pkg.
module lcam_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [lcam_pkg::SizeW-1:0] size_i,
  input  logic                     up_valid_i,
  output logic                     up_ready_o,
  input  lcam_pkg::lcam_chain_t    up_data_i,
  output logic                     dn_valid_o,
  input  logic                     dn_ready_i,
  output lcam_pkg::lcam_chain_t    dn_data_o
);

  logic                           valid_q;
  lcam_pkg::lcam_chain_t          data_q, data_d;
  logic [lcam_pkg::BlockW-1:0]    block;
  logic [lcam_pkg::BaseW-1:0]     span_end;
  logic [lcam_pkg::BlockW-1:0]    base_ext, end_ext;
  logic                           hit;

  assign block    = up_data_i.sector[lcam_pkg::SectorW-1:lcam_pkg::BlockShift];
  assign span_end = up_data_i.base + lcam_pkg::BaseW'(size_i);
  assign base_ext = lcam_pkg::BlockW'(up_data_i.base);
  assign end_ext  = lcam_pkg::BlockW'(span_end);
  // zero-size disks never match since end equals base
  assign hit      = en_i && !up_data_i.found && (block >= base_ext) && (block < end_ext);

  always_comb begin
    data_d      = up_data_i;
    data_d.base = span_end;
    if (hit) begin
      data_d.found    = 1'b1;
      data_d.hit      = lcam_pkg::DiskIdxW'(CellIdx);
      data_d.hit_base = up_data_i.base;
      data_d.hit_end  = span_end;
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

// ===== hw/rtl/lcam_finish.sv =====
// lcam_finish: two register stages after the cell chain that form the
// disk-relative sector and the merge byte count. Depends on lcam_pkg.
module lcam_finish (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  up_valid_i,
  output logic                  up_ready_o,
  input  lcam_pkg::lcam_chain_t up_data_i,
  output logic                  dn_valid_o,
  input  logic                  dn_ready_i,
  output lcam_pkg::lcam_out_t   dn_data_o
);

  // stage a: relative sector, room left on the disk, sectors wanted
  logic                            a_valid_q;
  logic                            a_ready;
  logic                            a_found_q;
  logic [lcam_pkg::DiskIdxW-1:0]   a_hit_q;
  logic [lcam_pkg::SectorW-1:0]    a_rel_q, a_rel_d;
  logic [lcam_pkg::RoomW-1:0]      a_room_q, a_room_d;
  logic [lcam_pkg::WantW-1:0]      a_want_q, a_want_d;
  logic [lcam_pkg::PendW-1:0]      a_pend_q;
  logic [lcam_pkg::OfferW-1:0]     a_offer_q;
  logic [lcam_pkg::SectorW-1:0]    base_sect, end_sect;
  logic [lcam_pkg::PendW:0]        total_bytes;

  // stage b: output register
  logic                            b_valid_q;
  logic                            b_ready;
  lcam_pkg::lcam_out_t             b_data_q, b_data_d;
  logic                            fits;
  logic [lcam_pkg::PendW:0]        room_bytes, pend_ext;

  assign base_sect   = {(lcam_pkg::SectorW-1)'(up_data_i.hit_base), 1'b0};
  assign end_sect    = {(lcam_pkg::SectorW-1)'(up_data_i.hit_end), 1'b0};
  assign a_rel_d     = up_data_i.sector - base_sect;
  assign a_room_d    = lcam_pkg::RoomW'(end_sect - up_data_i.sector);
  assign total_bytes = {1'b0, up_data_i.pending_bytes}
                       + (lcam_pkg::PendW + 1)'(up_data_i.offered_bytes);
  assign a_want_d    = total_bytes[lcam_pkg::PendW:lcam_pkg::SectorShift];

  assign b_ready    = !b_valid_q || dn_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign up_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= up_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && up_valid_i) begin
      a_found_q <= up_data_i.found;
      a_hit_q   <= up_data_i.hit;
      a_rel_q   <= a_rel_d;
      a_room_q  <= a_room_d;
      a_want_q  <= a_want_d;
      a_pend_q  <= up_data_i.pending_bytes;
      a_offer_q <= up_data_i.offered_bytes;
    end
  end

  assign fits       = lcam_pkg::RoomW'(a_want_q) <= a_room_q;
  // only used when room is below want, so the low bits of room suffice
  assign room_bytes = {a_room_q[lcam_pkg::WantW-1:0], {lcam_pkg::SectorShift{1'b0}}};
  assign pend_ext   = {1'b0, a_pend_q};

  always_comb begin
    b_data_d = '0;
    if (!a_found_q) begin
      b_data_d.out_of_range = 1'b1;
    end else begin
      b_data_d.disk_index  = a_hit_q;
      b_data_d.disk_sector = a_rel_q;
      if (fits) begin
        b_data_d.merge_bytes = a_offer_q;
      end else if (room_bytes > pend_ext) begin
        b_data_d.merge_bytes = lcam_pkg::OfferW'(room_bytes - pend_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

  assign dn_valid_o = b_valid_q;
  assign dn_data_o  = b_data_q;

endmodule

// ===== hw/rtl/linear_concat_address_map_core.sv =====
// linear_concat_address_map_core: maps a volume sector to a member disk.
// Pipeline: one cell stage per disk plus two finishing stages from input
// beat to result beat. Throughput: one beat per cycle while out_o.ready holds.
// Reset: disk count 1, all disk sizes 0, pipeline empty.
// Depends on lcam_pkg, lcam_stream_if, lcam_cell and lcam_finish.
module linear_concat_address_map_core #(
  parameter int unsigned MAX_DISKS = lcam_pkg::MaxDisksDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  lcam_stream_if.sink   in_i,
  lcam_stream_if.sink   cfg_i,
  lcam_stream_if.source out_o
);

  localparam int unsigned SizeRegs =
    (MAX_DISKS < lcam_pkg::NumSizeRegs) ? MAX_DISKS : lcam_pkg::NumSizeRegs;

  logic [lcam_pkg::CountW-1:0] disk_count_q;
  logic [lcam_pkg::SizeW-1:0]  size_q [SizeRegs];
  logic [lcam_pkg::CountW-1:0] used_disks;
  logic                        cfg_we;

  logic                  chain_valid [MAX_DISKS+1];
  logic                  chain_ready [MAX_DISKS+1];
  lcam_pkg::lcam_chain_t chain_data  [MAX_DISKS+1];

  // configuration writes
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_count_q <= lcam_pkg::DiskCountRst;
    end else if (cfg_we && cfg_i.data.reg_index == lcam_pkg::RegDiskCount) begin
      disk_count_q <= cfg_i.data.wdata[lcam_pkg::CountW-1:0];
    end
  end

  for (genvar d = 0; d < SizeRegs; d++) begin : g_size
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        size_q[d] <= '0;
      end else if (cfg_we && cfg_i.data.reg_index ==
                   lcam_pkg::RegSizeDisk0 + lcam_pkg::RegIdxW'(d)) begin
        size_q[d] <= cfg_i.data.wdata;
      end
    end
  end

  // zero count means one disk, too many saturates
  always_comb begin
    if (disk_count_q == '0) begin
      used_disks = lcam_pkg::CountW'(1);
    end else if (disk_count_q > lcam_pkg::CountW'(MAX_DISKS)) begin
      used_disks = lcam_pkg::CountW'(MAX_DISKS);
    end else begin
      used_disks = disk_count_q;
    end
  end

  // chain entry
  always_comb begin
    chain_data[0]               = '0;
    chain_data[0].sector        = in_i.data.sector;
    chain_data[0].pending_bytes = in_i.data.pending_bytes;
    chain_data[0].offered_bytes = in_i.data.offered_bytes;
  end
  assign chain_valid[0] = in_i.valid;
  assign in_i.ready     = chain_ready[0];

  for (genvar i = 0; i < MAX_DISKS; i++) begin : g_cell
    logic [lcam_pkg::SizeW-1:0] cell_size;
    logic                       cell_en;

    if (i < SizeRegs) begin : g_reg
      assign cell_size = size_q[i];
    end else begin : g_none
      assign cell_size = '0;
    end
    assign cell_en = lcam_pkg::CountW'(i) < used_disks;

    lcam_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (cell_en),
      .size_i     (cell_size),
      .up_valid_i (chain_valid[i]),
      .up_ready_o (chain_ready[i]),
      .up_data_i  (chain_data[i]),
      .dn_valid_o (chain_valid[i+1]),
      .dn_ready_i (chain_ready[i+1]),
      .dn_data_o  (chain_data[i+1])
    );
  end

  lcam_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (chain_valid[MAX_DISKS]),
    .up_ready_o (chain_ready[MAX_DISKS]),
    .up_data_i  (chain_data[MAX_DISKS]),
    .dn_valid_o (out_o.valid),
    .dn_ready_i (out_o.ready),
    .dn_data_o  (out_o.data)
  );

  // an out-of-range beat carries no mapping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.out_of_range |->
      out_o.data.disk_index == '0 && out_o.data.disk_sector == '0 &&
      out_o.data.merge_bytes == '0)
    else $error("out-of-range result with nonzero fields");

  // input only stalls when every stage is full and the sink holds off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled with room in the pipeline");

  // a hit never names a disk beyond the cell chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.out_of_range |->
      lcam_pkg::CountW'(out_o.data.disk_index) < lcam_pkg::CountW'(MAX_DISKS))
    else $error("result names a disk beyond the chain");

endmodule
